// ===== rtl/core/wwgp_pkg.sv =====
// ----------------------------------------------------------------------------
// wwgp_pkg
// Shared widths, register indexes, font table and character mapping for the
// word-wrapping glyph placer.
// ----------------------------------------------------------------------------
package wwgp_pkg;

  localparam int MAX_WORD_DEF = 16;
  localparam int COORD_W      = 12;
  localparam int GLYPH_W      = 35;
  localparam int IDX_W        = 6;
  localparam int CALC_W       = 14;
  localparam int CFG_IDX_W    = 2;
  localparam int NUM_GLYPHS   = 49;

  localparam logic [COORD_W-1:0] COORD_MAX   = 12'hfff;
  localparam logic [IDX_W-1:0]   BLANK_INDEX = 6'd36;
  localparam logic [7:0]         CHAR_SPACE  = 8'h20;

  localparam logic [3:0] ADV_NORMAL   = 4'd6;
  localparam logic [3:0] ADV_DOUBLE   = 4'd12;
  localparam logic [4:0] PITCH_NORMAL = 5'd9;
  localparam logic [4:0] PITCH_DOUBLE = 5'd18;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 2'd0,
    REG_ORIGIN_Y    = 2'd1,
    REG_WRAP_WIDTH  = 2'd2,
    REG_DOUBLE_SIZE = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CALC_W-1:0]  a;
    logic [CALC_W-1:0]  b;
    logic               cin;
    logic [COORD_W-1:0] limit;
  } calc_req_t;

  typedef struct packed {
    logic [CALC_W-1:0] sum;
    logic              above;
  } calc_rsp_t;

  localparam logic [GLYPH_W-1:0] GLYPH_ROM [NUM_GLYPHS] = '{
    {5'h0e,5'h11,5'h11,5'h1f,5'h11,5'h11,5'h11}, {5'h1e,5'h11,5'h11,5'h1e,5'h11,5'h11,5'h1e},
    {5'h0e,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0e}, {5'h1e,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1e},
    {5'h1f,5'h10,5'h10,5'h1e,5'h10,5'h10,5'h1f}, {5'h1f,5'h10,5'h10,5'h1e,5'h10,5'h10,5'h10},
    {5'h0e,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0e}, {5'h11,5'h11,5'h11,5'h1f,5'h11,5'h11,5'h11},
    {5'h1f,5'h04,5'h04,5'h04,5'h04,5'h04,5'h1f}, {5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0c},
    {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11}, {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1f},
    {5'h11,5'h1b,5'h15,5'h15,5'h11,5'h11,5'h11}, {5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11},
    {5'h0e,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0e}, {5'h1e,5'h11,5'h11,5'h1e,5'h10,5'h10,5'h10},
    {5'h0e,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0d}, {5'h1e,5'h11,5'h11,5'h1e,5'h14,5'h12,5'h11},
    {5'h0e,5'h11,5'h10,5'h0e,5'h01,5'h11,5'h0e}, {5'h1f,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
    {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0e}, {5'h11,5'h11,5'h11,5'h11,5'h0a,5'h0a,5'h04},
    {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0a}, {5'h11,5'h11,5'h0a,5'h04,5'h0a,5'h11,5'h11},
    {5'h11,5'h11,5'h0a,5'h04,5'h04,5'h04,5'h04}, {5'h1f,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1f},
    {5'h0e,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0e}, {5'h04,5'h0c,5'h04,5'h04,5'h04,5'h04,5'h0e},
    {5'h0e,5'h11,5'h01,5'h06,5'h08,5'h10,5'h1f}, {5'h0e,5'h11,5'h01,5'h06,5'h01,5'h11,5'h0e},
    {5'h02,5'h06,5'h0a,5'h12,5'h1f,5'h02,5'h02}, {5'h1f,5'h10,5'h1e,5'h01,5'h01,5'h11,5'h0e},
    {5'h0e,5'h11,5'h10,5'h1e,5'h11,5'h11,5'h0e}, {5'h1f,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
    {5'h0e,5'h11,5'h11,5'h0e,5'h11,5'h11,5'h0e}, {5'h0e,5'h11,5'h11,5'h0f,5'h01,5'h11,5'h0e},
    {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00}, {5'h00,5'h00,5'h00,5'h00,5'h00,5'h0c,5'h0c},
    {5'h00,5'h00,5'h00,5'h00,5'h04,5'h04,5'h08}, {5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04},
    {5'h0e,5'h11,5'h01,5'h06,5'h04,5'h00,5'h04}, {5'h04,5'h04,5'h08,5'h00,5'h00,5'h00,5'h00},
    {5'h00,5'h00,5'h00,5'h1f,5'h00,5'h00,5'h00}, {5'h00,5'h00,5'h08,5'h15,5'h02,5'h00,5'h00},
    {5'h01,5'h02,5'h02,5'h04,5'h08,5'h08,5'h10}, {5'h00,5'h0c,5'h0c,5'h00,5'h0c,5'h0c,5'h00},
    {5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02}, {5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08},
    {5'h19,5'h1a,5'h02,5'h04,5'h08,5'h0b,5'h13}
  };

  function automatic logic [IDX_W-1:0] glyph_index(input logic [7:0] b);
    logic [7:0]       u;
    logic [IDX_W-1:0] idx;
    u = (b >= 8'h61 && b <= 8'h7a) ? b - 8'd32 : b;
    if (u >= 8'h41 && u <= 8'h5a) begin
      idx = IDX_W'(u - 8'h41);
    end else if (u >= 8'h30 && u <= 8'h39) begin
      idx = IDX_W'(u - 8'h30) + 6'd26;
    end else begin
      unique case (u)
        8'h20:   idx = 6'd36;
        8'h2e:   idx = 6'd37;
        8'h2c:   idx = 6'd38;
        8'h21:   idx = 6'd39;
        8'h3f:   idx = 6'd40;
        8'h27:   idx = 6'd41;
        8'h2d:   idx = 6'd42;
        8'h7e:   idx = 6'd43;
        8'h2f:   idx = 6'd44;
        8'h3a:   idx = 6'd45;
        8'h28:   idx = 6'd46;
        8'h29:   idx = 6'd47;
        8'h25:   idx = 6'd48;
        default: idx = BLANK_INDEX;
      endcase
    end
    return idx;
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph_pattern(input logic [IDX_W-1:0] idx);
    logic [GLYPH_W-1:0] bits;
    if (idx < IDX_W'(NUM_GLYPHS)) begin
      bits = GLYPH_ROM[idx];
    end else begin
      bits = GLYPH_ROM[BLANK_INDEX];
    end
    return bits;
  endfunction

endpackage

// ===== rtl/core/wwgp_channels.sv =====
// ----------------------------------------------------------------------------
// wwgp_channels
// Valid/ready channels of the glyph placer: text input, placement records
// and configuration writes.
// ----------------------------------------------------------------------------
interface wwgp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface wwgp_out_if;
  logic                          valid;
  logic                          ready;
  logic [wwgp_pkg::COORD_W-1:0]  glyph_x;
  logic [wwgp_pkg::COORD_W-1:0]  glyph_y;
  logic [wwgp_pkg::GLYPH_W-1:0]  glyph_bits;
  logic                          scale_two;
  logic                          last_of_word;

  modport source (output valid, output glyph_x, output glyph_y, output glyph_bits,
                  output scale_two, output last_of_word, input ready);
  modport sink   (input valid, input glyph_x, input glyph_y, input glyph_bits,
                  input scale_two, input last_of_word, output ready);
endinterface

interface wwgp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wwgp_pkg::CFG_IDX_W-1:0] index;
  logic [wwgp_pkg::COORD_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/wwgp_ram.sv =====
// ----------------------------------------------------------------------------
// wwgp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wwgp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/wwgp_calc.sv =====
// ----------------------------------------------------------------------------
// wwgp_calc
// Shared adder with carry-in and limit compare; serves cursor offset,
// wrap test, line step and cursor advance.
// ----------------------------------------------------------------------------
module wwgp_calc (
  input  wwgp_pkg::calc_req_t req,
  output wwgp_pkg::calc_rsp_t rsp
);
  import wwgp_pkg::*;

  logic [CALC_W-1:0] sum;

  assign sum       = req.a + req.b + CALC_W'(req.cin);
  assign rsp.sum   = sum;
  assign rsp.above = sum > CALC_W'(req.limit);

endmodule

// ===== rtl/core/word_wrapping_glyph_placer_core.sv =====
// ----------------------------------------------------------------------------
// word_wrapping_glyph_placer_core
// Buffers each word of a byte stream, wraps it to the next line when it does
// not fit, and emits one glyph placement record per non-space character.
// Each byte is accepted, then decoded; the placer takes no new byte until that
// is done or, when the byte closes a word, until the flush ends. A flush runs the
// wrap test (offset, compare), an optional line step, a word store read and a
// record load per record, and a finishing step; a held record stalls the next load.
// Reset (rst, synchronous): registers to defaults, cursor at 0,0, word empty;
// the word store is not cleared.
// ----------------------------------------------------------------------------
module word_wrapping_glyph_placer_core #(
  parameter int MAX_WORD = wwgp_pkg::MAX_WORD_DEF
) (
  input  logic       clk,
  input  logic       rst,
  wwgp_in_if.sink    text_ch,
  wwgp_out_if.source glyph_ch,
  wwgp_cfg_if.sink   cfg_ch
);
  import wwgp_pkg::*;

  localparam int CW = $clog2(MAX_WORD + 1);
  localparam int AW = $clog2(MAX_WORD);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_DIFF   = 8'b0000_0100,
    S_WRAP   = 8'b0000_1000,
    S_LINE   = 8'b0001_0000,
    S_FETCH  = 8'b0010_0000,
    S_OUT    = 8'b0100_0000,
    S_TAIL   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [COORD_W-1:0] wrap_width;
  logic               double_size;
  logic [COORD_W-1:0] cursor_x;
  logic [COORD_W-1:0] cursor_y;
  logic               at_start;
  logic [CW-1:0]      word_count;
  logic [CW-1:0]      rec_idx;
  logic [7:0]         cur_byte;
  logic               cur_eot;
  logic [COORD_W-1:0] diff;
  logic               diff_pos;

  logic               out_valid;
  logic [COORD_W-1:0] glyph_x;
  logic [COORD_W-1:0] glyph_y;
  logic [GLYPH_W-1:0] glyph_bits;
  logic               scale_two;
  logic               last_of_word;

  logic [3:0]         adv;
  logic [4:0]         pitch;
  logic [CW+1:0]      count_x3;
  logic [CW+3:0]      span;
  logic [CW-1:0]      idx_inc;
  logic               is_space;
  logic               word_full;
  logic [COORD_W-1:0] sat_sum;
  logic [IDX_W-1:0]   store_rdata;

  calc_req_t calc_req;
  calc_rsp_t calc_rsp;

  assign adv       = double_size ? ADV_DOUBLE : ADV_NORMAL;
  assign pitch     = double_size ? PITCH_DOUBLE : PITCH_NORMAL;
  assign count_x3  = {2'b00, word_count} + {1'b0, word_count, 1'b0};
  assign span      = double_size ? {count_x3, 2'b00} : {1'b0, count_x3, 1'b0};
  assign idx_inc   = rec_idx + 1'b1;
  assign is_space  = (cur_byte == CHAR_SPACE);
  assign word_full = (word_count == CW'(MAX_WORD - 1));
  assign sat_sum   = (calc_rsp.sum[CALC_W-1:COORD_W] != '0) ? COORD_MAX
                                                            : calc_rsp.sum[COORD_W-1:0];

  always_comb begin
    calc_req.a     = {2'b00, cursor_x};
    calc_req.b     = CALC_W'(adv);
    calc_req.cin   = 1'b0;
    calc_req.limit = wrap_width;
    unique case (state)
      S_DIFF: begin
        calc_req.b   = ~{2'b00, origin_x};
        calc_req.cin = 1'b1;
      end
      S_WRAP: begin
        calc_req.a = {2'b00, diff};
        calc_req.b = CALC_W'(span);
      end
      S_LINE: begin
        calc_req.a = {2'b00, cursor_y};
        calc_req.b = CALC_W'(pitch);
      end
      default: begin
      end
    endcase
  end

  wwgp_calc u_calc (
    .req (calc_req),
    .rsp (calc_rsp)
  );

  wwgp_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_WORD)
  ) u_word_store (
    .clk   (clk),
    .we    (state == S_DECODE && !is_space),
    .waddr (word_count[AW-1:0]),
    .wdata (glyph_index(cur_byte)),
    .raddr (rec_idx[AW-1:0]),
    .rdata (store_rdata)
  );

  assign text_ch.ready = (state == S_IDLE);
  assign cfg_ch.ready  = 1'b1;

  assign glyph_ch.valid        = out_valid;
  assign glyph_ch.glyph_x      = glyph_x;
  assign glyph_ch.glyph_y      = glyph_y;
  assign glyph_ch.glyph_bits   = glyph_bits;
  assign glyph_ch.scale_two    = scale_two;
  assign glyph_ch.last_of_word = last_of_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      origin_x    <= '0;
      origin_y    <= '0;
      wrap_width  <= COORD_MAX;
      double_size <= 1'b0;
      cursor_x    <= '0;
      cursor_y    <= '0;
      at_start    <= 1'b1;
      word_count  <= '0;
      rec_idx     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_reg_t'(cfg_ch.index))
          REG_ORIGIN_X:    origin_x    <= cfg_ch.data;
          REG_ORIGIN_Y:    origin_y    <= cfg_ch.data;
          REG_WRAP_WIDTH:  wrap_width  <= cfg_ch.data;
          REG_DOUBLE_SIZE: double_size <= cfg_ch.data[0];
        endcase
      end

      if (out_valid && glyph_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (text_ch.valid) begin
            cur_byte <= text_ch.text_byte;
            cur_eot  <= text_ch.end_of_text;
            if (at_start) begin
              cursor_x <= origin_x;
              cursor_y <= origin_y;
              at_start <= 1'b0;
            end
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (is_space) begin
            state <= S_DIFF;
          end else begin
            word_count <= word_count + 1'b1;
            state      <= (cur_eot || word_full) ? S_DIFF : S_IDLE;
          end
        end
        S_DIFF: begin
          diff     <= calc_rsp.sum[COORD_W-1:0];
          diff_pos <= !calc_rsp.sum[CALC_W-1] && (calc_rsp.sum != '0);
          state    <= S_WRAP;
        end
        S_WRAP: begin
          rec_idx <= '0;
          if (diff_pos && calc_rsp.above) begin
            cursor_x <= origin_x;
            state    <= S_LINE;
          end else begin
            state <= (word_count == '0) ? S_TAIL : S_FETCH;
          end
        end
        S_LINE: begin
          cursor_y <= sat_sum;
          state    <= (word_count == '0) ? S_TAIL : S_FETCH;
        end
        S_FETCH: begin
          if (!out_valid || glyph_ch.ready) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid    <= 1'b1;
          glyph_x      <= cursor_x;
          glyph_y      <= cursor_y;
          glyph_bits   <= glyph_pattern(store_rdata);
          scale_two    <= double_size;
          last_of_word <= (idx_inc == word_count);
          cursor_x     <= sat_sum;
          rec_idx      <= idx_inc;
          state        <= (idx_inc == word_count) ? S_TAIL : S_FETCH;
        end
        S_TAIL: begin
          word_count <= '0;
          if (cur_eot) begin
            cursor_x <= origin_x;
            cursor_y <= origin_y;
            at_start <= 1'b1;
          end else if (is_space) begin
            cursor_x <= sat_sum;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_below_max: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (word_count < CW'(MAX_WORD)))
    else $error("word count reached the store depth while idle");

  a_record_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(glyph_ch.valid) |-> $past(state == S_OUT))
    else $error("record raised outside the record load step");

  a_wrap_at_origin: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINE) |-> (cursor_x == origin_x))
    else $error("line step without cursor at line start");

  a_no_load_over_held: assert property (@(posedge clk) disable iff (rst)
    (glyph_ch.valid && !glyph_ch.ready) |=> (state != S_OUT))
    else $error("record load while previous beat still held");

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives text bytes into the glyph placer under several register settings.
// Each placement record is checked against a local model of the word
// buffer, the wrap rule and the 5x7 font.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wwgp_pkg::*;

  localparam int WORD_CAP    = MAX_WORD_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_GAP  = 48;
  localparam int HOLD_SPAN   = 300;
  localparam int PHASE_BEATS = 23;
  localparam int NUM_PHASES  = 6;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [8*13-1:0] FONT_SYMBOLS = " .,!?'-~/:()%";

  localparam logic [55:0] FONT_ROWS [NUM_GLYPHS] = '{
    56'h0e11111f111111, 56'h1e11111e11111e, 56'h0e11101010110e, 56'h1e11111111111e,
    56'h1f10101e10101f, 56'h1f10101e101010, 56'h0e11101711110e, 56'h1111111f111111,
    56'h1f04040404041f, 56'h0702020202120c, 56'h11121418141211, 56'h1010101010101f,
    56'h111b1515111111, 56'h11111915131111, 56'h0e11111111110e, 56'h1e11111e101010,
    56'h0e11111115120d, 56'h1e11111e141211, 56'h0e11100e01110e, 56'h1f040404040404,
    56'h1111111111110e, 56'h111111110a0a04, 56'h1111111515150a, 56'h11110a040a1111,
    56'h11110a04040404, 56'h1f01020408101f, 56'h0e11131519110e, 56'h040c040404040e,
    56'h0e11010608101f, 56'h0e11010601110e, 56'h02060a121f0202, 56'h1f101e0101110e,
    56'h0e11101e11110e, 56'h1f010204080808, 56'h0e11110e11110e, 56'h0e11110f01110e,
    56'h00000000000000, 56'h00000000000c0c, 56'h00000000040408, 56'h04040404040004,
    56'h0e110106040004, 56'h04040800000000, 56'h0000001f000000, 56'h00000815020000,
    56'h01020204080810, 56'h000c0c000c0c00, 56'h02040808080402, 56'h08040202020408,
    56'h191a0204080b13
  };

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [GLYPH_W-1:0] bits;
    logic               scale;
    logic               last;
  } placement_t;

  typedef struct {
    logic [7:0]         text;
    logic               eot;
    bit                 typed;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [GLYPH_W-1:0] bits;
  } text_row_t;

  typedef struct {
    logic [COORD_W-1:0] org_x;
    logic [COORD_W-1:0] org_y;
    logic [COORD_W-1:0] wrap;
    logic               dbl;
  } layout_t;

  localparam logic [GLYPH_W-1:0] GLYPH_A =
    {5'h0e, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11, 5'h11};
  localparam logic [GLYPH_W-1:0] GLYPH_Z =
    {5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1f};

  text_row_t opening_rows [25] = '{
    '{"A",   1'b1, 1'b1, 12'd0, 12'd0, GLYPH_A},
    '{8'hff, 1'b1, 1'b1, 12'd0, 12'd0, '0},
    '{8'h00, 1'b1, 1'b1, 12'd0, 12'd0, '0},
    '{"z",   1'b1, 1'b1, 12'd0, 12'd0, GLYPH_Z},
    '{8'h5c, 1'b1, 1'b1, 12'd0, 12'd0, '0},
    '{"h",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{"i",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{",",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{" ",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{" ",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{"o",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{"k",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{"!",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{" ",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{"9",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{"%",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{"~",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{"(",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{")",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{".",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{"?",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{"'",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{"-",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{"/",   1'b0, 1'b0, 12'd0, 12'd0, '0},
    '{":",   1'b1, 1'b0, 12'd0, 12'd0, '0}
  };

  layout_t layouts [NUM_PHASES] = '{
    '{12'd0,    12'd0,    12'd4095, 1'b0},
    '{12'd4095, 12'd4095, 12'd0,    1'b1},
    '{12'd30,   12'd100,  12'd120,  1'b0},
    '{12'd0,    12'd4050, 12'd0,    1'b1},
    '{12'd0,    12'd0,    12'd0,    1'b0},
    '{12'd4000, 12'd7,    12'd4095, 1'b0}
  };

  logic clk;
  logic rst;

  wwgp_in_if  text_if ();
  wwgp_out_if glyph_if ();
  wwgp_cfg_if reg_if ();

  word_wrapping_glyph_placer_core #(
    .MAX_WORD (WORD_CAP)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .text_ch  (text_if),
    .glyph_ch (glyph_if),
    .cfg_ch   (reg_if)
  );

  placement_t placements_due [$];

  logic [COORD_W-1:0] org_x  = '0;
  logic [COORD_W-1:0] org_y  = '0;
  logic [COORD_W-1:0] wrap_w = COORD_MAX;
  logic               dbl    = 1'b0;
  logic [COORD_W-1:0] pen_x  = '0;
  logic [COORD_W-1:0] pen_y  = '0;
  logic [IDX_W-1:0]   word_buf [WORD_CAP];
  int                 word_len = 0;
  bit                 new_string = 1'b1;

  int mismatch_count = 0;
  int text_beats     = 0;
  int tx_gap_pct     = 37;
  int rx_stall_pct   = 70;
  bit rx_hold_req    = 1'b0;
  int quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [COORD_W-1:0] clamp_coord(input int v);
    return (v > int'(COORD_MAX)) ? COORD_MAX : COORD_W'(v);
  endfunction

  function automatic logic [IDX_W-1:0] char_slot(input logic [7:0] c);
    logic [7:0] u;
    u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    if (u >= "A" && u <= "Z") return IDX_W'(u - "A");
    if (u >= "0" && u <= "9") return IDX_W'(u - "0") + IDX_W'(26);
    for (int i = 0; i < 13; i++) begin
      if (FONT_SYMBOLS[8*(12-i) +: 8] == u) return IDX_W'(36 + i);
    end
    return IDX_W'(36);
  endfunction

  function automatic logic [GLYPH_W-1:0] font_bits(input logic [IDX_W-1:0] idx);
    logic [55:0] r;
    r = FONT_ROWS[idx];
    return {r[52:48], r[44:40], r[36:32], r[28:24], r[20:16], r[12:8], r[4:0]};
  endfunction

  task automatic place_word();
    int adv;
    int pitch;
    placement_t p;
    adv   = dbl ? 12 : 6;
    pitch = dbl ? 18 : 9;
    if (pen_x > org_x && (int'(pen_x) - int'(org_x)) + word_len * adv > int'(wrap_w)) begin
      pen_x = org_x;
      pen_y = clamp_coord(int'(pen_y) + pitch);
    end
    for (int i = 0; i < word_len; i++) begin
      p.x     = pen_x;
      p.y     = pen_y;
      p.bits  = font_bits(word_buf[i]);
      p.scale = dbl;
      p.last  = (i == word_len - 1);
      placements_due.push_back(p);
      pen_x = clamp_coord(int'(pen_x) + adv);
    end
    word_len = 0;
  endtask

  task automatic predict_placements(input logic [7:0] b, input logic eot);
    if (new_string) begin
      pen_x      = org_x;
      pen_y      = org_y;
      new_string = 1'b0;
    end
    if (b == SPACE_CHAR) begin
      place_word();
      pen_x = clamp_coord(int'(pen_x) + (dbl ? 12 : 6));
    end else begin
      if (word_len < WORD_CAP) word_buf[word_len] = char_slot(b);
      word_len++;
      if (word_len >= WORD_CAP) place_word();
    end
    if (eot) begin
      if (word_len > 0) place_word();
      pen_x      = org_x;
      pen_y      = org_y;
      new_string = 1'b1;
    end
  endtask

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 50) $display("MISMATCH: %s", msg);
  endtask

  task automatic check_placement();
    placement_t want;
    if (placements_due.size() == 0) begin
      flag_mismatch($sformatf("unexpected record at x=%0d y=%0d",
                              glyph_if.glyph_x, glyph_if.glyph_y));
      return;
    end
    want = placements_due.pop_front();
    if (glyph_if.glyph_x !== want.x)
      flag_mismatch($sformatf("glyph_x %0d, want %0d", glyph_if.glyph_x, want.x));
    if (glyph_if.glyph_y !== want.y)
      flag_mismatch($sformatf("glyph_y %0d, want %0d", glyph_if.glyph_y, want.y));
    if (glyph_if.glyph_bits !== want.bits)
      flag_mismatch($sformatf("glyph_bits %h, want %h", glyph_if.glyph_bits, want.bits));
    if (glyph_if.scale_two !== want.scale)
      flag_mismatch($sformatf("scale_two %b, want %b", glyph_if.scale_two, want.scale));
    if (glyph_if.last_of_word !== want.last)
      flag_mismatch($sformatf("last_of_word %b, want %b", glyph_if.last_of_word, want.last));
  endtask

  always @(posedge clk) begin
    if (!rst && glyph_if.valid && glyph_if.ready) check_placement();
  end

  always @(posedge clk) begin
    if (rst || (text_if.valid && text_if.ready) || (glyph_if.valid && glyph_if.ready)
        || (reg_if.valid && reg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int hold_left;
    hold_left = 0;
    glyph_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HOLD_SPAN;
      end
      if (hold_left > 0) begin
        glyph_if.ready <= 1'b0;
        hold_left--;
      end else begin
        glyph_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // enter and leave at a falling edge; valid stays high into the next beat
  task automatic send_text(input logic [7:0] b, input logic eot);
    while ($urandom_range(99) < tx_gap_pct) begin
      text_if.valid <= 1'b0;
      @(negedge clk);
    end
    text_if.valid       <= 1'b1;
    text_if.text_byte   <= b;
    text_if.end_of_text <= eot;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    predict_placements(b, eot);
    text_beats++;
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [COORD_W-1:0] val);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= val;
    @(posedge clk);
    while (!reg_if.ready) @(posedge clk);
    case (idx)
      REG_ORIGIN_X:    org_x  = val;
      REG_ORIGIN_Y:    org_y  = val;
      REG_WRAP_WIDTH:  wrap_w = val;
      REG_DOUBLE_SIZE: dbl    = val[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic load_layout(input layout_t s);
    write_reg(REG_ORIGIN_X, s.org_x);
    write_reg(REG_ORIGIN_Y, s.org_y);
    write_reg(REG_WRAP_WIDTH, s.wrap);
    write_reg(REG_DOUBLE_SIZE, {{(COORD_W-1){1'b0}}, s.dbl});
    reg_if.valid <= 1'b0;
  endtask

  task automatic settle_idle();
    while (placements_due.size() != 0) @(negedge clk);
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  function automatic logic [7:0] random_char();
    logic [7:0] pick;
    case ($urandom_range(9))
      0, 1, 2: pick = 8'("A" + $urandom_range(25));
      3, 4, 5: pick = 8'("a" + $urandom_range(25));
      6:       pick = 8'("0" + $urandom_range(9));
      7, 8:    pick = FONT_SYMBOLS[8*(12-$urandom_range(12, 1)) +: 8];
      default: pick = 8'($urandom_range(255));
    endcase
    return pick;
  endfunction

  // mostly words with random content, a few stray bytes and overlong words
  task automatic send_random_text(input int quota);
    int goal;
    int len;
    int spaces;
    int k;
    bit ends;
    goal = text_beats + quota;
    while (text_beats < goal) begin
      if ($urandom_range(99) < 8) begin
        send_text(8'($urandom_range(255)), $urandom_range(7) == 0);
      end else begin
        len  = ($urandom_range(99) < 15) ? $urandom_range(20, 12) : $urandom_range(7);
        ends = (len > 0) && ($urandom_range(5) == 0);
        for (k = 0; k < len; k++) send_text(random_char(), ends && k == len - 1);
        if (!ends) begin
          spaces = $urandom_range(2, 1);
          for (k = 0; k < spaces; k++)
            send_text(SPACE_CHAR, (k == spaces - 1) && ($urandom_range(7) == 0));
        end
      end
    end
  endtask

  initial begin
    rst                 = 1'b1;
    text_if.valid       = 1'b0;
    text_if.text_byte   = '0;
    text_if.end_of_text = 1'b0;
    reg_if.valid        = 1'b0;
    reg_if.index        = REG_ORIGIN_X;
    reg_if.data         = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening_rows[i]) begin
      send_text(opening_rows[i].text, opening_rows[i].eot);
      if (opening_rows[i].typed) begin
        void'(placements_due.pop_back());
        placements_due.push_back('{opening_rows[i].x, opening_rows[i].y,
                                   opening_rows[i].bits, 1'b0, 1'b1});
      end
    end
    text_if.valid <= 1'b0;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle_idle();
      tx_gap_pct   = (phase < 2) ? 37 : (phase < 4) ? 70 : 0;
      rx_stall_pct = (phase < 2) ? 70 : (phase < 4) ? 37 : 0;
      if (phase == 4)
        load_layout('{12'($urandom_range(200)), 12'($urandom_range(4095)),
                      12'($urandom_range(400)), 1'($urandom_range(1))});
      else
        load_layout(layouts[phase]);
      if (phase == 4) rx_hold_req = 1'b1;
      send_random_text(PHASE_BEATS);
      text_if.valid <= 1'b0;
    end

    settle_idle();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
